// ----- rtl/core/tinyjambu_aead_engine_unit_assert.svh -----
// ----------------------------------------------------------------------------
// TinyJAMBU engine assertion macros
// Concurrent assertion wrappers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TINYJAMBU_AEAD_ENGINE_UNIT_ASSERT_SVH
`define TINYJAMBU_AEAD_ENGINE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// plain property check
`define TJAE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define TJAE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define TJAE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TJAE_ASSERT(lbl, prop, msg)
`define TJAE_ASSERT_IMPL(lbl, ante, cons, msg)
`define TJAE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/tjae_pkg.sv -----
// ----------------------------------------------------------------------------
// TinyJAMBU engine package
// Shared constants, types and the 32-round word step of the keyed NLFSR.
// ----------------------------------------------------------------------------
package tjae_pkg;

  // Round counts of the scheme
  localparam int LONG_ROUNDS  = 1024;
  localparam int SHORT_ROUNDS = 384;

  // One word step (32 rounds) per cycle
  localparam int LONG_STEPS  = LONG_ROUNDS / 32;
  localparam int SHORT_STEPS = SHORT_ROUNDS / 32;
  localparam int MAX_STEPS   = (LONG_STEPS > SHORT_STEPS) ? LONG_STEPS : SHORT_STEPS;
  // at least two bits: the low two bits pick the key word
  localparam int CNT_W = ($clog2(MAX_STEPS + 1) < 2) ? 2 : $clog2(MAX_STEPS + 1);

  typedef logic [3:0][31:0] state_t;

  // Item actions
  typedef enum logic [2:0] {
    ACT_BEGIN = 3'd0,
    ACT_NONCE = 3'd1,
    ACT_ASSOC = 3'd2,
    ACT_ENC   = 3'd3,
    ACT_DEC   = 3'd4,
    ACT_FINAL = 3'd5
  } act_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_KEY_LOW     = 3'd0,
    REG_KEY_HIGH    = 3'd1,
    REG_FRAME_NONCE = 3'd2,
    REG_FRAME_ASSOC = 3'd3,
    REG_FRAME_TEXT  = 3'd4,
    REG_FRAME_FINAL = 3'd5
  } cfg_reg_e;

  // Framing defaults
  localparam logic [7:0] FRAME_NONCE_RST = 8'd16;
  localparam logic [7:0] FRAME_ASSOC_RST = 8'd48;
  localparam logic [7:0] FRAME_TEXT_RST  = 8'd80;
  localparam logic [7:0] FRAME_FINAL_RST = 8'd112;

  // Datapath operations
  typedef enum logic [1:0] {
    DP_HOLD  = 2'd0,
    DP_CLEAR = 2'd1,
    DP_STEP  = 2'd2,
    DP_MIX   = 2'd3
  } dp_op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_RUN  = 3'd1,
    ST_FIN2 = 3'd2,
    ST_MIX  = 3'd3,
    ST_DONE = 3'd4
  } seq_state_e;

  // Control word from sequencer to NLFSR datapath
  typedef struct packed {
    dp_op_e      op;
    logic [31:0] mix1;
    logic [31:0] mix3;
    logic [31:0] key_word;
  } dp_ctl_t;

  // 32 rounds of the NLFSR with one key word
  function automatic state_t tjae_step(input state_t s, input logic [31:0] kw);
    logic [31:0] t1, t2, t3, t4, f;
    state_t      r;
    t1 = (s[1] >> 15) | (s[2] << 17);
    t2 = (s[2] >> 6)  | (s[3] << 26);
    t3 = (s[2] >> 21) | (s[3] << 11);
    t4 = (s[2] >> 27) | (s[3] << 5);
    f  = s[0] ^ t1 ^ ~(t2 & t3) ^ t4 ^ kw;
    r[0] = s[1];
    r[1] = s[2];
    r[2] = s[3];
    r[3] = f;
    return r;
  endfunction

endpackage

// ----- rtl/core/tjae_nlfsr.sv -----
// ----------------------------------------------------------------------------
// TinyJAMBU NLFSR datapath
// 128-bit state register with a shared 32-round step unit and xor mixing.
// ----------------------------------------------------------------------------
module tjae_nlfsr
  import tjae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_ctl_t     ctl_i,
  output logic [31:0] s2_o
);

  state_t s_q, s_d;

  // next state per operation
  always_comb begin
    s_d = s_q;
    unique case (ctl_i.op)
      DP_HOLD:  s_d = s_q;
      DP_CLEAR: s_d = '0;
      DP_STEP:  s_d = tjae_step(s_q, ctl_i.key_word);
      DP_MIX: begin
        s_d[1] = s_q[1] ^ ctl_i.mix1;
        s_d[3] = s_q[3] ^ ctl_i.mix3;
      end
      default:  s_d = s_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else begin
      s_q <= s_d;
    end
  end

  assign s2_o = s_q[2];

endmodule

// ----- rtl/core/tinyjambu_aead_engine_unit.sv -----
// ----------------------------------------------------------------------------
// TinyJAMBU-128 AEAD engine
// States per word: begin runs RUN only; nonce/assoc words run RUN and MIX;
// encrypt/decrypt run RUN, MIX and DONE; finalize runs RUN, FIN2, RUN, MIX
// and DONE, which waits until the result register is free (32 rounds/cycle).
// One word in flight at a time; the step count of the NLFSR loop sets the rate.
// Reset clears the NLFSR state and key, and loads the default framing bits.
// ----------------------------------------------------------------------------
`include "tinyjambu_aead_engine_unit_assert.svh"

module tinyjambu_aead_engine_unit
  import tjae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic [63:0] expected_tag_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_word_o,
  output logic [2:0]  result_bytes_o,
  output logic        is_tag_o,
  output logic [63:0] tag_value_o,
  output logic        tag_match_o
);

  // configuration registers
  logic [63:0] key_low_q, key_high_q;
  logic [7:0]  frame_nonce_q, frame_assoc_q, frame_text_q, frame_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q     <= '0;
      key_high_q    <= '0;
      frame_nonce_q <= FRAME_NONCE_RST;
      frame_assoc_q <= FRAME_ASSOC_RST;
      frame_text_q  <= FRAME_TEXT_RST;
      frame_final_q <= FRAME_FINAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_LOW:     key_low_q     <= cfg_data_i;
        REG_KEY_HIGH:    key_high_q    <= cfg_data_i;
        REG_FRAME_NONCE: frame_nonce_q <= cfg_data_i[7:0];
        REG_FRAME_ASSOC: frame_assoc_q <= cfg_data_i[7:0];
        REG_FRAME_TEXT:  frame_text_q  <= cfg_data_i[7:0];
        REG_FRAME_FINAL: frame_final_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer and item registers
  seq_state_e  state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        long_q, long_d;
  logic        phase_q, phase_d;
  act_e        action_q;
  logic [31:0] word_q;
  logic [2:0]  count_q;
  logic [63:0] expected_q;
  logic [31:0] res_q, res_d;
  logic [31:0] tag_lo_q, tag_lo_d, tag_hi_q, tag_hi_d;
  logic        load_item, load_out;
  logic        out_valid_q;
  logic [31:0] result_word_q;
  logic [2:0]  result_bytes_q;
  logic        is_tag_q, tag_match_q;
  logic [63:0] tag_value_q;

  dp_ctl_t     ctl;
  logic [31:0] s2;
  logic [31:0] key_sel;
  logic [31:0] mask;
  logic        partial;
  logic [31:0] res;
  logic        last_step;
  logic [2:0]  count_in;

  // key word j mod 4
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    key_sel = key_low_q[31:0];
      2'd1:    key_sel = key_low_q[63:32];
      2'd2:    key_sel = key_high_q[31:0];
      default: key_sel = key_high_q[63:32];
    endcase
  end

  // byte count outside 1..4 means a full word
  assign count_in = (byte_count_i == 3'd0 || byte_count_i > 3'd4) ? 3'd4 : byte_count_i;

  // valid byte lanes
  always_comb begin
    case (count_q)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
  end

  assign partial   = (count_q != 3'd4);
  assign res       = (s2 ^ word_q) & mask;
  assign last_step = long_q ? (cnt_q == CNT_W'(LONG_STEPS - 1))
                            : (cnt_q == CNT_W'(SHORT_STEPS - 1));
  assign in_ready_o = (state_q == ST_IDLE);

  // next state and datapath control
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    long_d    = long_q;
    phase_d   = phase_q;
    res_d     = res_q;
    tag_lo_d  = tag_lo_q;
    tag_hi_d  = tag_hi_q;
    load_item = 1'b0;
    load_out  = 1'b0;
    ctl.op       = DP_HOLD;
    ctl.mix1     = '0;
    ctl.mix3     = '0;
    ctl.key_word = key_sel;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          load_item = 1'b1;
          cnt_d     = '0;
          phase_d   = 1'b0;
          unique case (act_e'(action_i)) inside
            ACT_BEGIN: begin
              ctl.op  = DP_CLEAR;
              long_d  = 1'b1;
              state_d = ST_RUN;
            end
            ACT_NONCE: begin
              ctl.op   = DP_MIX;
              ctl.mix1 = {24'd0, frame_nonce_q};
              long_d   = 1'b0;
              state_d  = ST_RUN;
            end
            ACT_ASSOC: begin
              ctl.op   = DP_MIX;
              ctl.mix1 = {24'd0, frame_assoc_q};
              long_d   = 1'b0;
              state_d  = ST_RUN;
            end
            ACT_ENC, ACT_DEC: begin
              ctl.op   = DP_MIX;
              ctl.mix1 = {24'd0, frame_text_q};
              long_d   = 1'b1;
              state_d  = ST_RUN;
            end
            ACT_FINAL: begin
              ctl.op   = DP_MIX;
              ctl.mix1 = {24'd0, frame_final_q};
              long_d   = 1'b1;
              state_d  = ST_RUN;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        ctl.op = DP_STEP;
        cnt_d  = cnt_q + CNT_W'(1);
        if (last_step) begin
          cnt_d = '0;
          if (action_q == ACT_BEGIN) begin
            state_d = ST_IDLE;
          end else if (action_q == ACT_FINAL && !phase_q) begin
            state_d = ST_FIN2;
          end else begin
            state_d = ST_MIX;
          end
        end
      end
      ST_FIN2: begin
        // first tag word, then frame again for the short run
        tag_lo_d = s2;
        ctl.op   = DP_MIX;
        ctl.mix1 = {24'd0, frame_final_q};
        phase_d  = 1'b1;
        long_d   = 1'b0;
        state_d  = ST_RUN;
      end
      ST_MIX: begin
        state_d = ST_IDLE;
        case (action_q) inside
          ACT_NONCE: begin
            ctl.op   = DP_MIX;
            ctl.mix3 = word_q;
          end
          ACT_ASSOC: begin
            ctl.op   = DP_MIX;
            ctl.mix3 = word_q & mask;
            ctl.mix1 = partial ? {29'd0, count_q} : 32'd0;
          end
          ACT_ENC, ACT_DEC: begin
            ctl.op   = DP_MIX;
            res_d    = res;
            ctl.mix3 = (action_q == ACT_ENC) ? (word_q & mask) : res;
            ctl.mix1 = partial ? {29'd0, count_q} : 32'd0;
            state_d  = ST_DONE;
          end
          ACT_FINAL: begin
            tag_hi_d = s2;
            state_d  = ST_DONE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      long_q      <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      long_q  <= long_d;
      phase_q <= phase_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (load_item) begin
      action_q   <= act_e'(action_i);
      word_q     <= data_word_i;
      count_q    <= count_in;
      expected_q <= expected_tag_i;
    end
    res_q    <= res_d;
    tag_lo_q <= tag_lo_d;
    tag_hi_q <= tag_hi_d;
    if (load_out) begin
      if (action_q == ACT_FINAL) begin
        result_word_q  <= '0;
        result_bytes_q <= '0;
        is_tag_q       <= 1'b1;
        tag_value_q    <= {tag_hi_q, tag_lo_q};
        tag_match_q    <= ({tag_hi_q, tag_lo_q} == expected_q);
      end else begin
        result_word_q  <= res_q;
        result_bytes_q <= count_q;
        is_tag_q       <= 1'b0;
        tag_value_q    <= '0;
        tag_match_q    <= 1'b0;
      end
    end
  end

  tjae_nlfsr u_nlfsr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .s2_o   (s2)
  );

  assign out_valid_o    = out_valid_q;
  assign result_word_o  = result_word_q;
  assign result_bytes_o = result_bytes_q;
  assign is_tag_o       = is_tag_q;
  assign tag_value_o    = tag_value_q;
  assign tag_match_o    = tag_match_q;

  // step counter never passes the run length
  `TJAE_ASSERT_IMPL(a_cnt_range, state_q == ST_RUN,
    cnt_q < (long_q ? CNT_W'(LONG_STEPS) : CNT_W'(SHORT_STEPS)), "step counter overrun")
  // an accepted word starts the round loop unless the action is unused
  `TJAE_ASSERT_NEXT(a_start_run, in_valid_i && in_ready_o && action_i <= 3'd5,
    state_q == ST_RUN, "accepted word did not start the round loop")
  // tag results carry no message bytes
  `TJAE_ASSERT_IMPL(a_tag_clean, out_valid_o && is_tag_o,
    result_bytes_o == 3'd0 && result_word_o == 32'd0, "tag result carries data")
  // message results carry no tag
  `TJAE_ASSERT_IMPL(a_msg_clean, out_valid_o && !is_tag_o,
    tag_value_o == 64'd0 && !tag_match_o && result_bytes_o != 3'd0, "message result carries tag")

endmodule

// ----- test/tjae_checker.sv -----
// ----------------------------------------------------------------------------
// TinyJAMBU engine checker
// Watches the configuration port and both word channels of the engine,
// keeps its own copy of the NLFSR state and registers, predicts each
// ciphertext, plaintext and tag word, and compares the results in order.
// ----------------------------------------------------------------------------
module tjae_checker
  import tjae_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  action_i,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic [63:0] expected_tag_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] result_word_i,
  input  logic [2:0]  result_bytes_i,
  input  logic        is_tag_i,
  input  logic [63:0] tag_value_i,
  input  logic        tag_match_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic        tag_flag;
    logic [63:0] tag;
    logic        match;
  } jambu_out_t;

  // model copy of the engine
  logic [31:0] nlfsr [4];
  logic [63:0] key_lo, key_hi;
  logic [7:0]  frm_nonce, frm_assoc, frm_text, frm_final;
  jambu_out_t  owed_words [$];

  // R rounds of the keyed NLFSR, 32 rounds per word step
  task automatic jambu_rounds(input int rounds);
    logic [31:0] t1, t2, t3, t4, fb, kw;
    for (int j = 0; j < rounds / 32; j++) begin
      case (j % 4)
        0:       kw = key_lo[31:0];
        1:       kw = key_lo[63:32];
        2:       kw = key_hi[31:0];
        default: kw = key_hi[63:32];
      endcase
      t1 = (nlfsr[1] >> 15) | (nlfsr[2] << 17);
      t2 = (nlfsr[2] >> 6)  | (nlfsr[3] << 26);
      t3 = (nlfsr[2] >> 21) | (nlfsr[3] << 11);
      t4 = (nlfsr[2] >> 27) | (nlfsr[3] << 5);
      fb = nlfsr[0] ^ t1 ^ ~(t2 & t3) ^ t4 ^ kw;
      nlfsr[0] = nlfsr[1];
      nlfsr[1] = nlfsr[2];
      nlfsr[2] = nlfsr[3];
      nlfsr[3] = fb;
    end
  endtask

  // apply one accepted word to the state, queue the word it returns
  task automatic jambu_absorb(input logic [2:0] act, input logic [31:0] din,
                              input logic [2:0] cnt, input logic [63:0] want_tag);
    logic [2:0]  n;
    logic        partial;
    logic [31:0] mask, res;
    logic [63:0] tag;
    jambu_out_t  r;
    // zero or more than four bytes means a full word
    n       = (cnt == 3'd0 || cnt > 3'd4) ? 3'd4 : cnt;
    partial = (n < 3'd4);
    mask    = 32'hFFFF_FFFF >> (8 * (4 - n));
    case (act)
      ACT_BEGIN: begin
        for (int i = 0; i < 4; i++) nlfsr[i] = '0;
        jambu_rounds(LONG_ROUNDS);
      end
      ACT_NONCE: begin
        nlfsr[1] ^= {24'd0, frm_nonce};
        jambu_rounds(SHORT_ROUNDS);
        nlfsr[3] ^= din;
      end
      ACT_ASSOC: begin
        nlfsr[1] ^= {24'd0, frm_assoc};
        jambu_rounds(SHORT_ROUNDS);
        nlfsr[3] ^= din & mask;
        if (partial) nlfsr[1] ^= {29'd0, n};
      end
      ACT_ENC, ACT_DEC: begin
        nlfsr[1] ^= {24'd0, frm_text};
        jambu_rounds(LONG_ROUNDS);
        res = (nlfsr[2] ^ din) & mask;
        // the plaintext side feeds the state in both directions
        nlfsr[3] ^= (act == ACT_ENC) ? (din & mask) : res;
        if (partial) nlfsr[1] ^= {29'd0, n};
        r = '{word: res, nbytes: n, tag_flag: 1'b0, tag: '0, match: 1'b0};
        owed_words.push_back(r);
      end
      ACT_FINAL: begin
        nlfsr[1] ^= {24'd0, frm_final};
        jambu_rounds(LONG_ROUNDS);
        tag[31:0] = nlfsr[2];
        nlfsr[1] ^= {24'd0, frm_final};
        jambu_rounds(SHORT_ROUNDS);
        tag[63:32] = nlfsr[2];
        r = '{word: '0, nbytes: '0, tag_flag: 1'b1, tag: tag, match: (tag == want_tag)};
        owed_words.push_back(r);
      end
      default: ; // unused codes are dropped
    endcase
  endtask

  // compare one returned word with the oldest prediction
  task automatic jambu_compare();
    jambu_out_t e;
    if (owed_words.size() == 0) begin
      $error("unexpected result word: word %h bytes %0d tag %b", result_word_i,
             result_bytes_i, is_tag_i);
      fail_count_o++;
    end else begin
      e = owed_words.pop_front();
      if (result_word_i !== e.word) begin
        $error("result_word: expected %h, got %h", e.word, result_word_i);
        fail_count_o++;
      end
      if (result_bytes_i !== e.nbytes) begin
        $error("result_bytes: expected %0d, got %0d", e.nbytes, result_bytes_i);
        fail_count_o++;
      end
      if (is_tag_i !== e.tag_flag) begin
        $error("is_tag: expected %b, got %b", e.tag_flag, is_tag_i);
        fail_count_o++;
      end
      if (tag_value_i !== e.tag) begin
        $error("tag_value: expected %h, got %h", e.tag, tag_value_i);
        fail_count_o++;
      end
      if (tag_match_i !== e.match) begin
        $error("tag_match: expected %b, got %b", e.match, tag_match_i);
        fail_count_o++;
      end
    end
  endtask

  // track registers, accepted words and returned words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) nlfsr[i] = '0;
      key_lo    = '0;
      key_hi    = '0;
      frm_nonce = FRAME_NONCE_RST;
      frm_assoc = FRAME_ASSOC_RST;
      frm_text  = FRAME_TEXT_RST;
      frm_final = FRAME_FINAL_RST;
      owed_words.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_KEY_LOW:     key_lo    = cfg_data_i;
          REG_KEY_HIGH:    key_hi    = cfg_data_i;
          REG_FRAME_NONCE: frm_nonce = cfg_data_i[7:0];
          REG_FRAME_ASSOC: frm_assoc = cfg_data_i[7:0];
          REG_FRAME_TEXT:  frm_text  = cfg_data_i[7:0];
          REG_FRAME_FINAL: frm_final = cfg_data_i[7:0];
          default: ;
        endcase
      end
      // a word leaving now cannot belong to the word entering now
      if (out_valid_i && out_ready_i) jambu_compare();
      if (in_valid_i && in_ready_i)
        jambu_absorb(action_i, data_word_i, byte_count_i, expected_tag_i);
      pending_o = owed_words.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// TinyJAMBU engine testbench
// Drives directed and random word streams through the engine under several
// key and framing settings, including encrypt/decrypt replays that expect
// the first tag or one bit off it, with random gaps and result stalls.
// The checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import tjae_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT  = 500_000;
  localparam int         SETTLE_CYC   = 60;   // covers the longest word latency
  localparam int         PHASE_WORDS  = 205;
  localparam int         NUM_PHASES   = 6;
  localparam logic [2:0] ACT_UNUSED6  = 3'd6;
  localparam logic [2:0] ACT_UNUSED7  = 3'd7;
  localparam logic [2:0] REG_UNUSED6  = 3'd6;
  localparam logic [2:0] REG_UNUSED7  = 3'd7;
  localparam logic [2:0] FULL_WORD    = 3'd4;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_we         = 1'b0;
  logic [2:0]  cfg_idx        = '0;
  logic [63:0] cfg_data       = '0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [2:0]  action         = '0;
  logic [31:0] data_word      = '0;
  logic [2:0]  byte_count     = 3'd4;
  logic [63:0] expected_tag   = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [31:0] result_word;
  logic [2:0]  result_bytes;
  logic        is_tag;
  logic [63:0] tag_value;
  logic        tag_match;
  int          fails, pending;

  int          cycles     = 0;
  int          words_sent = 0;
  bit          gaps_on    = 1'b1;
  bit          stall_on   = 1'b1;
  int          stall_left = 0;
  int          stall_draw;

  // message kept for a replay in the other direction
  logic [31:0] msg_nonce [3];
  logic [31:0] msg_ad [$];
  logic [31:0] msg_txt [$];
  logic [2:0]  ad_last_cnt, txt_last_cnt, msg_dir;
  logic [31:0] seen_text [$];
  logic [63:0] seen_tag;

  tinyjambu_aead_engine_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .data_word_i    (data_word),
    .byte_count_i   (byte_count),
    .expected_tag_i (expected_tag),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .result_word_o  (result_word),
    .result_bytes_o (result_bytes),
    .is_tag_o       (is_tag),
    .tag_value_o    (tag_value),
    .tag_match_o    (tag_match)
  );

  tjae_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .action_i       (action),
    .data_word_i    (data_word),
    .byte_count_i   (byte_count),
    .expected_tag_i (expected_tag),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .result_word_i  (result_word),
    .result_bytes_i (result_bytes),
    .is_tag_i       (is_tag),
    .tag_value_i    (tag_value),
    .tag_match_i    (tag_match),
    .fail_count_o   (fails),
    .pending_o      (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: a random stall after each accepted word
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      stall_draw = stall_on ? $urandom_range(0, 7) : 0;
      stall_left <= stall_draw;
      out_ready  <= (stall_draw == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // keep returned words for replays
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (is_tag) seen_tag <= tag_value;
      else seen_text.push_back(result_word);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // present one word and hold it until taken
  task automatic put_word(input logic [2:0] act, input logic [31:0] din,
                          input logic [2:0] cnt, input logic [63:0] want_tag);
    int gap;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    action       <= act;
    data_word    <= din;
    byte_count   <= cnt;
    expected_tag <= want_tag;
    do @(posedge clk_i); while (!in_ready);
    if (act != ACT_UNUSED6 && act != ACT_UNUSED7) words_sent++;
  endtask

  // stop sending and let the engine go quiet
  task automatic settle();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // phase settings: all low, all high, then random keys and framing
  task automatic load_config(input int phase);
    for (int r = REG_KEY_LOW; r <= REG_FRAME_FINAL; r++) begin
      case (phase)
        1:       cfg_write(3'(r), 64'd0);
        2:       cfg_write(3'(r), '1);
        default: cfg_write(3'(r), rand64());
      endcase
    end
    if (phase > 2) begin
      cfg_write(REG_UNUSED6, rand64());
      cfg_write(REG_UNUSED7, rand64());
    end
  endtask

  // begin, nonce, assoc, text, finalize; a replay runs the other direction
  task automatic send_message(input bit replay);
    int          n_ad, n_txt;
    logic [2:0]  dir;
    logic [63:0] want;
    if (!replay) begin
      msg_dir = ($urandom_range(0, 2) == 0) ? ACT_DEC : ACT_ENC;
      for (int i = 0; i < 3; i++) msg_nonce[i] = $urandom;
      msg_ad.delete();
      msg_txt.delete();
      n_ad  = $urandom_range(0, 3);
      n_txt = $urandom_range(1, 4);
      for (int i = 0; i < n_ad; i++) msg_ad.push_back($urandom);
      for (int i = 0; i < n_txt; i++) msg_txt.push_back($urandom);
      ad_last_cnt  = 3'($urandom_range(1, 4));
      txt_last_cnt = 3'($urandom_range(1, 4));
      seen_text.delete();
    end
    dir = replay ? ((msg_dir == ACT_ENC) ? ACT_DEC : ACT_ENC) : msg_dir;
    put_word(ACT_BEGIN, $urandom, 3'($urandom_range(0, 7)), rand64());
    for (int i = 0; i < 3; i++)
      put_word(ACT_NONCE, msg_nonce[i], 3'($urandom_range(0, 7)), rand64());
    for (int i = 0; i < msg_ad.size(); i++)
      put_word(ACT_ASSOC, msg_ad[i], (i == msg_ad.size() - 1) ? ad_last_cnt : FULL_WORD,
               rand64());
    for (int i = 0; i < msg_txt.size(); i++)
      put_word(dir, replay ? seen_text[i] : msg_txt[i],
               (i == msg_txt.size() - 1) ? txt_last_cnt : FULL_WORD, rand64());
    // replay expects the first tag, now and then with one bit flipped
    want = rand64();
    if (replay)
      want = seen_tag ^ (($urandom_range(0, 3) == 0) ? (64'd1 << $urandom_range(0, 63)) : '0);
    put_word(ACT_FINAL, $urandom, 3'($urandom_range(0, 7)), want);
  endtask

  // stimulus and verdict
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: words before begin, byte counts at all codes, unused
    // actions, extremes of data and tag, finalize twice in a row
    put_word(ACT_ASSOC, 32'hFFFF_FFFF, 3'd2, '0);
    put_word(ACT_ENC, 32'h0000_0000, FULL_WORD, '0);
    put_word(ACT_BEGIN, 32'h0000_0000, 3'd0, '1);
    put_word(ACT_NONCE, 32'h0000_0000, 3'd0, '0);
    put_word(ACT_NONCE, 32'hFFFF_FFFF, 3'd7, '1);
    put_word(ACT_NONCE, $urandom, 3'd1, rand64());
    put_word(ACT_ASSOC, 32'hFFFF_FFFF, FULL_WORD, '0);
    put_word(ACT_ASSOC, $urandom, 3'd1, '0);
    put_word(ACT_ASSOC, $urandom, 3'd3, '0);
    put_word(ACT_ENC, 32'hFFFF_FFFF, FULL_WORD, '0);
    put_word(ACT_ENC, $urandom, 3'd1, '0);
    put_word(ACT_ENC, $urandom, 3'd2, '0);
    put_word(ACT_ENC, $urandom, 3'd3, '0);
    put_word(ACT_DEC, $urandom, 3'd0, '0);
    put_word(ACT_DEC, $urandom, 3'd5, '0);
    put_word(ACT_DEC, 32'h0000_0000, 3'd7, '0);
    put_word(ACT_DEC, 32'hFFFF_FFFF, 3'd2, '0);
    put_word(ACT_UNUSED6, $urandom, 3'd6, rand64());
    put_word(ACT_UNUSED7, $urandom, FULL_WORD, rand64());
    put_word(ACT_FINAL, $urandom, FULL_WORD, 64'd0);
    put_word(ACT_FINAL, $urandom, FULL_WORD, '1);

    // random phases, each under its own setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        settle();
        load_config(ph);
      end
      while (words_sent < 21 + (ph + 1) * PHASE_WORDS) begin
        gaps_on  = ($urandom_range(0, 3) != 0);
        stall_on = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            // noise: any action in any order, any byte count
            repeat ($urandom_range(1, 8))
              put_word(3'($urandom_range(0, 7)), $urandom, 3'($urandom_range(0, 7)),
                       rand64());
          end
          3, 4, 5: send_message(1'b0);
          default: begin
            settle();
            send_message(1'b0);
            settle();
            send_message(1'b1);
          end
        endcase
      end
    end

    settle();
    if (fails == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
